// File: design/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared constants and types for the LRU cache lookup block.
// ----------------------------------------------------------------------------
package lcl_pkg;

    localparam int ENTRIES    = 5;
    localparam int KEY_WIDTH  = 16;
    localparam int DATA_WIDTH = 32;

    typedef logic [KEY_WIDTH-1:0]  t_key;
    typedef logic [DATA_WIDTH-1:0] t_data;

    // Content of one slot, handed from a cell to the one behind it.
    typedef struct packed {
        logic  valid;
        t_key  key;
        t_data value;
    } t_slot;

    // Lookup result rippling from the front of the row to the back.
    typedef struct packed {
        logic  found;
        t_data data;
    } t_chain;

endpackage

// File: design/lcl_if.sv
// ----------------------------------------------------------------------------
// lcl_req_if / lcl_rsp_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface lcl_req_if
    import lcl_pkg::*;
();
    logic  valid;
    logic  ready;
    t_key  req_key;
    t_data fill_value;

    modport source (output valid, output req_key, output fill_value, input ready);
    modport sink   (input valid, input req_key, input fill_value, output ready);
endinterface

interface lcl_rsp_if
    import lcl_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  hit;
    t_data data_out;

    modport source (output valid, output hit, output data_out, input ready);
    modport sink   (input valid, input hit, input data_out, output ready);
endinterface

// File: design/lcl_cell.sv
// ----------------------------------------------------------------------------
// lcl_cell
// One cache slot: compares its key with the request and either holds or
// takes the content of the slot in front of it.
// ----------------------------------------------------------------------------
module lcl_cell
    import lcl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_key   i_key,
    input  t_slot  i_prev,
    input  t_chain i_chain,
    output t_slot  o_slot,
    output t_chain o_chain
);

    logic  r_valid;
    t_key  r_key;
    t_data r_value;
    logic  w_match;
    logic  w_shift;

    assign w_match = r_valid && (r_key == i_key);
    // A match ahead freezes this cell; otherwise, when enabled, it takes the neighbor's slot.
    assign w_shift = i_en && !i_chain.found;

    always_comb begin
        o_chain.found = i_chain.found || w_match;
        if (i_chain.found) begin
            o_chain.data = i_chain.data;
        end else if (w_match) begin
            o_chain.data = r_value;
        end else begin
            o_chain.data = '0;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.key   = r_key;
    assign o_slot.value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

endmodule

// File: design/lru_cache_lookup_core.sv
// ----------------------------------------------------------------------------
// lru_cache_lookup_core
// Fully associative cache of ENTRIES slots kept in recency order.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries req_key and fill_value; o_rsp returns hit and data_out,
//   one response item per request item, in order.
//   Every slot cell compares its key with the request in the same cycle; the
//   first match ripples back along the row. On a hit the matching slot moves
//   to the front and its value is returned; on a miss all slots shift back,
//   the last drops out and the key with fill_value enters at the front.
//   Latency: the response is registered and is valid the cycle after the
//   request is accepted. Throughput: one item per cycle while o_rsp.ready is
//   high, set by the single compare-and-shift pass through the cell row.
//   A stalled receiver holds the response register; a new request is taken
//   in the same cycle the held response leaves, otherwise i_req.ready is low.
//   Reset (synchronous, active low) empties the cache by clearing all valid
//   bits at once and drops any pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_cache_lookup_core
    import lcl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lcl_req_if.sink   i_req,
    lcl_rsp_if.source o_rsp
);

    t_slot  w_slot  [ENTRIES];
    t_chain w_chain [ENTRIES+1];
    t_slot  w_front;
    logic   w_accept;
    logic   w_hit;
    t_data  w_data;

    logic   r_rsp_valid;
    logic   r_hit;
    t_data  r_data;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_chain[0].found = 1'b0;
    assign w_chain[0].data  = '0;

    assign w_hit  = w_chain[ENTRIES].found;
    assign w_data = w_hit ? w_chain[ENTRIES].data : i_req.fill_value;

    assign w_front.valid = 1'b1;
    assign w_front.key   = i_req.req_key;
    assign w_front.value = w_data;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lcl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_accept),
            .i_key   (i_req.req_key),
            .i_prev  ((g == 0) ? w_front : w_slot[(g == 0) ? 0 : g-1]),
            .i_chain (w_chain[g]),
            .o_slot  (w_slot[g]),
            .o_chain (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit  <= w_hit;
            r_data <= w_data;
        end
    end

    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.hit      = r_hit;
    assign o_rsp.data_out = r_data;

    logic [ENTRIES-1:0] w_match_vec;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_match
        assign w_match_vec[g] = w_slot[g].valid && (w_slot[g].key == i_req.req_key);
    end

    a_rsp_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_rsp_valid)
        else $error("response missing after accepted item");

    a_front_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_slot[0].valid && w_slot[0].key == $past(i_req.req_key)))
        else $error("front slot does not hold the last requested key");

    a_no_duplicates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_vec))
        else $error("key present in more than one valid slot");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_slot[0].valid) && $stable(w_slot[ENTRIES-1].valid))
        else $error("slot contents changed without an accepted item");

endmodule

// File: tb/sv/lru_cache_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// lru_cache_lookup_core_tb
// Checks hit flag and returned value of the LRU cache for every request item.
// A directed table covers the empty cache, extreme keys and values, hits at
// the front, middle and back, and evictions. A random part follows, built
// mostly from a small working set of keys so hits and evictions are frequent.
// Each response is compared in order with a has_exp row's expectation, else a
// recency-ordered software copy of the cache. Both sides idle at random;
// the receiver once holds off long enough to back the request side up.
// ----------------------------------------------------------------------------
module lru_cache_lookup_core_tb
    import lcl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 850;
    localparam int N_DIRECTED = 20;
    localparam int IDLE_PCT   = 8;
    localparam int LONG_HOLD  = 80;
    localparam int DRAIN      = 8;

    typedef struct packed {
        logic  hit;
        t_data data;
    } t_lookup;

    typedef struct packed {
        t_key  key;
        t_data fill;
        logic  has_exp;
        logic  hit;
        t_data data;
    } t_dir_row;

    // has_exp rows carry an expectation read straight off the cache contents
    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        '{16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
        '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF},
        '{16'h0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000},
        '{16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{16'h0001, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0001},
        '{16'h0002, 32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000},
        '{16'h0004, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF},
        '{16'h0000, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h0000_0000},
        '{16'h8000, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'hAAAA_AAAA},
        '{16'hFFFF, 32'h5555_5555, 1'b1, 1'b0, 32'h5555_5555},
        '{16'h0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{16'h0004, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{16'hAAAA, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000},
        '{16'h5555, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000},
        '{16'h0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{16'hAAAA, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{16'hAAAB, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
        '{16'hAAAB, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
        '{16'h7FFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000}
    };

    logic i_clk;
    logic i_rst_n;

    lcl_req_if req_if ();
    lcl_rsp_if rsp_if ();

    lru_cache_lookup_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // software copy of the cache, slot 0 most recent
    t_key    cache_key   [ENTRIES];
    t_data   cache_value [ENTRIES];
    logic    cache_valid [ENTRIES];

    t_lookup pending_lookups [$];
    int      mismatches;
    int      responses_seen;
    int      item_index;
    t_key    work_keys [9];
    int      work_size;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400us;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_lookup lru_lookup(t_key key, t_data fill);
        t_lookup res;
        int      found;
        found = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && cache_valid[i] && cache_key[i] == key) begin
                found = i;
            end
        end
        if (found >= 0) begin
            res.hit  = 1'b1;
            res.data = cache_value[found];
        end else begin
            res.hit  = 1'b0;
            res.data = fill;
            found    = ENTRIES - 1;
        end
        for (int i = found; i > 0; i--) begin
            cache_key[i]   = cache_key[i-1];
            cache_value[i] = cache_value[i-1];
            cache_valid[i] = cache_valid[i-1];
        end
        cache_key[0]   = key;
        cache_value[0] = res.data;
        cache_valid[0] = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        mismatches++;
        $display("MISMATCH %0t: %s got %h expected %h", $realtime, what, got, exp);
    endtask

    // caller stands at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input t_key key, input t_data fill, input logic has_exp,
                             input t_lookup exp);
        t_lookup pred;
        while ((item_index < 200 || item_index >= 400)
               && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.req_key    = key;
        req_if.fill_value = fill;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pred = lru_lookup(key, fill);
        pending_lookups.push_back(has_exp ? exp : pred);
        item_index++;
        @(negedge i_clk);
    endtask

    function automatic t_key pick_key();
        int r;
        int slot;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return work_keys[$urandom_range(0, work_size - 1)];
        end
        if (r < 85) begin
            slot = $urandom_range(0, ENTRIES - 1);
            if (cache_valid[slot]) begin
                return cache_key[slot];
            end
        end
        return t_key'($urandom);
    endfunction

    function automatic t_data pick_fill();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 10) begin
            return '1;
        end
        return t_data'($urandom);
    endfunction

    // response side
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!hold_done && responses_seen >= 500) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (responses_seen >= 300 && responses_seen < 500) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_lookup exp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            responses_seen++;
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected item", {31'b0, rsp_if.hit}, 32'b0);
            end else begin
                exp = pending_lookups.pop_front();
                if (rsp_if.hit !== exp.hit) begin
                    report_mismatch("hit", {31'b0, rsp_if.hit}, {31'b0, exp.hit});
                end
                if (rsp_if.data_out !== exp.data) begin
                    report_mismatch("data_out", rsp_if.data_out, exp.data);
                end
            end
        end
    end

    initial begin
        mismatches        = 0;
        responses_seen    = 0;
        item_index        = 0;
        work_size         = 1;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_key    = '0;
        req_if.fill_value = '0;
        rsp_if.ready      = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_valid[i] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIR_ROWS[r]) begin
            send_item(DIR_ROWS[r].key, DIR_ROWS[r].fill, DIR_ROWS[r].has_exp,
                      '{hit: DIR_ROWS[r].hit, data: DIR_ROWS[r].data});
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                work_size = $urandom_range(3, 9);
                for (int k = 0; k < 9; k++) begin
                    work_keys[k] = t_key'($urandom);
                end
            end
            if (n == 600) begin
                req_if.valid = 1'b0;
                while (pending_lookups.size() != 0) @(negedge i_clk);
            end
            send_item(pick_key(), pick_fill(), 1'b0, '0);
        end
        req_if.valid = 1'b0;

        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
